[sv/bb3ea_pkg.sv]
// ============================================================================
// bb3ea_pkg
// Shared widths, register indexes and the rounded-mean divider for the
// 3x3 edge-aware box blur.
// ============================================================================
package bb3ea_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int ROW_W      = 16;
    localparam int IMG_W_W    = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 12;   // 9 * 255 plus rounding bias
    localparam int CNT_W      = 4;
    localparam int RECIP_W    = 15;
    localparam int RECIP_SH   = 16;
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST = 16'd480;

    // ceil(2^16 / n); exact for dividends below 2^15
    localparam logic [RECIP_W-1:0] RECIP3 = 15'd21846;
    localparam logic [RECIP_W-1:0] RECIP9 = 15'd7282;

    // floor((2*sum + n) / (2*n)) == floor((sum + n/2) / n), n in {1,2,3,4,6,9}
    function automatic logic [CH_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                   input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0]  x;
        logic [SUM_W-1:0]  q;
        logic [PROD_W-1:0] prod;
        x    = sum + SUM_W'(cnt >> 1);
        prod = '0;
        q    = '0;
        case (cnt)
            4'd1: q = x;
            4'd2: q = x >> 1;
            4'd4: q = x >> 2;
            4'd3: begin
                prod = PROD_W'(x) * PROD_W'(RECIP3);
                q    = SUM_W'(prod >> RECIP_SH);
            end
            4'd6: begin
                prod = PROD_W'(x >> 1) * PROD_W'(RECIP3);
                q    = SUM_W'(prod >> RECIP_SH);
            end
            4'd9: begin
                prod = PROD_W'(x) * PROD_W'(RECIP9);
                q    = SUM_W'(prod >> RECIP_SH);
            end
            default: q = '0;
        endcase
        return q[CH_W-1:0];
    endfunction

endpackage

[sv/bb3ea_ram.sv]
// ============================================================================
// bb3ea_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ============================================================================
module bb3ea_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/box_blur_3x3_edge_aware.sv]
// ============================================================================
// box_blur_3x3_edge_aware
// 3x3 box blur over a raster-order RGB stream. Each channel is the rounded
// mean of the in-frame neighbors; line history lives in one line RAM.
// ============================================================================
//
//  channel  | ports                           | transfer when
//  ---------+---------------------------------+----------------------------
//  pixel in | s_valid/s_ready, s_in_*         | s_valid && s_ready
//  result   | m_valid/m_ready, m_out_*, flags | m_valid && m_ready
//  config   | cfg_wr_en, cfg_index, cfg_wdata | cfg_wr_en (no wait)
//
//  Each pixel goes through a line RAM read step, then a sum step and a divide
//  step for each of the n = 0..4 results it releases; s_ready stays low meanwhile.
//  The line RAM holds {older row, previous row} per column and is never
//  cleared; entries from above the frame are masked out of every sum.
//  A stalled result sits in the output register and holds the divide step.
//  Reset and any write to the width or height register restart the frame at row 0, column 0.
//
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = bb3ea_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [bb3ea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3ea_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bb3ea_pkg::CH_W-1:0]       s_in_red,
    input  logic [bb3ea_pkg::CH_W-1:0]       s_in_green,
    input  logic [bb3ea_pkg::CH_W-1:0]       s_in_blue,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bb3ea_pkg::CH_W-1:0]       m_out_red,
    output logic [bb3ea_pkg::CH_W-1:0]       m_out_green,
    output logic [bb3ea_pkg::CH_W-1:0]       m_out_blue,
    output logic [bb3ea_pkg::ROW_W-1:0]      m_out_row,
    output logic [COL_W-1:0]                 m_out_col,
    output logic                             m_last_of_run,
    output logic                             m_frame_end
);

    import bb3ea_pkg::*;

    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int MEM_W  = 2 * PIX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [IMG_W_W-1:0] img_width_reg;
    logic [ROW_W-1:0]   img_height_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [PIX_W-1:0]   px_reg;
    logic [PIX_W-1:0]   win_reg [9];
    logic [3:0]         pend_reg, pend_next;
    logic [ROW_W-1:0]   job_row_reg;
    logic [COL_W-1:0]   job_col_reg;

    logic [SUM_W-1:0]   sum_r_reg, sum_g_reg, sum_b_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ROW_W-1:0]   res_row_reg;
    logic [COL_W-1:0]   res_col_reg;
    logic               res_last_reg;
    logic               res_fend_reg;

    logic               m_valid_reg;
    logic [CH_W-1:0]    m_red_reg, m_green_reg, m_blue_reg;
    logic [ROW_W-1:0]   m_row_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic               m_last_reg, m_fend_reg;

    logic [WCNT_W-1:0]  eff_w_m1;
    logic [ROW_W-1:0]   eff_h_m1;
    logic               col_at_end, row_at_end;

    logic [MEM_W-1:0]   rd_data;
    logic               ram_we;

    logic [1:0]         sel;
    logic               sel_a, sel_b;
    logic [2:0]         rv, cv;
    logic [1:0]         nr, nc;
    logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
    logic               accept, out_free;

    // ------------------------------------------------------------------
    // Frame geometry
    // ------------------------------------------------------------------
    always_comb begin
        if (img_width_reg == '0) begin
            eff_w_m1 = '0;
        end else if (32'(img_width_reg) > 32'(MAX_WIDTH)) begin
            eff_w_m1 = WCNT_W'(MAX_WIDTH - 1);
        end else begin
            eff_w_m1 = WCNT_W'(img_width_reg - 1'b1);
        end
        eff_h_m1 = (img_height_reg == '0) ? '0 : img_height_reg - 1'b1;
    end

    assign col_at_end = (WCNT_W'(col_reg) == eff_w_m1);
    assign row_at_end = (row_reg == eff_h_m1);

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign ram_we   = (state_reg == ST_READ);

    // ------------------------------------------------------------------
    // Line RAM: {older row, previous row} per column
    // ------------------------------------------------------------------
    bb3ea_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (col_reg),
        .wr_data ({rd_data[PIX_W-1:0], px_reg}),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Result selection and neighbor masks
    // ------------------------------------------------------------------
    // pend bits in raster order: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
    always_comb begin
        if (pend_reg[0]) begin
            sel = 2'd0;
        end else if (pend_reg[1]) begin
            sel = 2'd1;
        end else if (pend_reg[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    assign sel_a = sel[1];
    assign sel_b = sel[0];

    // window row 0 is r-2, row 2 is r; same for columns
    assign rv = {1'b1, job_row_reg != '0, !sel_a && (job_row_reg > ROW_W'(1))};
    assign cv = {1'b1, job_col_reg != '0, !sel_b && (job_col_reg > COL_W'(1))};
    assign nr = 2'(rv[0]) + 2'(rv[1]) + 2'(rv[2]);
    assign nc = 2'(cv[0]) + 2'(cv[1]) + 2'(cv[2]);

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int wr = 0; wr < 3; wr++) begin
            for (int wc = 0; wc < 3; wc++) begin
                if (rv[wr] && cv[wc]) begin
                    sum_r = sum_r + SUM_W'(win_reg[wr*3+wc][3*CH_W-1:2*CH_W]);
                    sum_g = sum_g + SUM_W'(win_reg[wr*3+wc][2*CH_W-1:CH_W]);
                    sum_b = sum_b + SUM_W'(win_reg[wr*3+wc][CH_W-1:0]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                pend_next  = {row_at_end && col_at_end,
                              row_at_end && (col_reg != '0),
                              (row_reg != '0) && col_at_end,
                              (row_reg != '0) && (col_reg != '0)};
                state_next = (pend_next != '0) ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                pend_next  = pend_reg & ~(4'b0001 << sel);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (out_free) begin
                    state_next = (pend_reg != '0) ? ST_SUM : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_reg       <= '0;
            img_width_reg  <= IMAGE_WIDTH_RST;
            img_height_reg <= IMAGE_HEIGHT_RST;
            row_reg        <= '0;
            col_reg        <= '0;
            m_valid_reg    <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;

            if (cfg_wr_en && (cfg_index == REG_IMAGE_WIDTH ||
                              cfg_index == REG_IMAGE_HEIGHT)) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    img_width_reg <= cfg_wdata[IMG_W_W-1:0];
                end else begin
                    img_height_reg <= cfg_wdata[ROW_W-1:0];
                end
                row_reg <= '0;
                col_reg <= '0;
            end else if (state_reg == ST_READ) begin
                if (col_at_end) begin
                    col_reg <= '0;
                    row_reg <= row_at_end ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            if (state_reg == ST_READ) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= rd_data[MEM_W-1:PIX_W];
                win_reg[5] <= rd_data[PIX_W-1:0];
                win_reg[8] <= px_reg;
            end

            if (state_reg == ST_DIV && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg <= {s_in_red, s_in_green, s_in_blue};
        end
        if (state_reg == ST_READ) begin
            job_row_reg <= row_reg;
            job_col_reg <= col_reg;
        end
        if (state_reg == ST_SUM) begin
            sum_r_reg    <= sum_r;
            sum_g_reg    <= sum_g;
            sum_b_reg    <= sum_b;
            cnt_reg      <= CNT_W'(nr) * CNT_W'(nc);
            res_row_reg  <= job_row_reg - ROW_W'(!sel_a);
            res_col_reg  <= job_col_reg - COL_W'(!sel_b);
            res_last_reg <= (pend_reg & ~(4'b0001 << sel)) == '0;
            res_fend_reg <= (sel == 2'd3);
        end
        if (state_reg == ST_DIV && out_free) begin
            m_red_reg   <= round_mean(sum_r_reg, cnt_reg);
            m_green_reg <= round_mean(sum_g_reg, cnt_reg);
            m_blue_reg  <= round_mean(sum_b_reg, cnt_reg);
            m_row_reg   <= res_row_reg;
            m_col_reg   <= res_col_reg;
            m_last_reg  <= res_last_reg;
            m_fend_reg  <= res_fend_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_red     = m_red_reg;
    assign m_out_green   = m_green_reg;
    assign m_out_blue    = m_blue_reg;
    assign m_out_row     = m_row_reg;
    assign m_out_col     = m_col_reg;
    assign m_last_of_run = m_last_reg;
    assign m_frame_end   = m_fend_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fend_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_last_of_run)
        else $error("frame end result not marked last of run");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (pend_reg == '0))
        else $error("results pending while idle");

    a_count_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg == 4'd1 || cnt_reg == 4'd2 ||
                                   cnt_reg == 4'd3 || cnt_reg == 4'd4 ||
                                   cnt_reg == 4'd6 || cnt_reg == 4'd9))
        else $error("neighbor count outside divider range");

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_READ))
        else $error("accepted pixel did not start a line RAM read");

endmodule

[bench/blur_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// blur_checker
// Watches the pixel, result and register ports of the 3x3 box blur, keeps
// its own line stores and window, predicts every blurred pixel with its row,
// column and flags, and compares each result transfer against the oldest
// prediction.
// ============================================================================
module blur_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bb3ea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3ea_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [bb3ea_pkg::CH_W-1:0]       s_in_red,
    input  logic [bb3ea_pkg::CH_W-1:0]       s_in_green,
    input  logic [bb3ea_pkg::CH_W-1:0]       s_in_blue,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [bb3ea_pkg::CH_W-1:0]       m_out_red,
    input  logic [bb3ea_pkg::CH_W-1:0]       m_out_green,
    input  logic [bb3ea_pkg::CH_W-1:0]       m_out_blue,
    input  logic [bb3ea_pkg::ROW_W-1:0]      m_out_row,
    input  logic [$clog2(bb3ea_pkg::MAX_WIDTH_DEF)-1:0] m_out_col,
    input  logic                             m_last_of_run,
    input  logic                             m_frame_end,
    output int                               fail_count,
    output int                               pending
);

    localparam int LINE_MAX = bb3ea_pkg::MAX_WIDTH_DEF;
    localparam int COL_W    = $clog2(LINE_MAX);
    localparam int PIX_W    = bb3ea_pkg::PIX_W;
    localparam int PRINT_MAX = 40;

    typedef struct packed {
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
        logic [bb3ea_pkg::ROW_W-1:0] row;
        logic [COL_W-1:0]            col;
        logic                        last;
        logic                        fend;
    } blur_px_t;

    logic [bb3ea_pkg::IMG_W_W-1:0] width_reg;
    logic [bb3ea_pkg::ROW_W-1:0]   height_reg;
    logic [PIX_W-1:0]              older_line [LINE_MAX];
    logic [PIX_W-1:0]              prev_line  [LINE_MAX];
    logic [PIX_W-1:0]              win [9];
    int                            row_pos;
    int                            col_pos;
    blur_px_t                      blurred_q [$];

    task automatic flag_mismatch(input string msg);
        if (fail_count < PRINT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [7:0] rounded_mean(input int unsigned sum, input int unsigned n);
        return 8'((2 * sum + n) / (2 * n));
    endfunction

    // Mean over the in-frame neighbors of (i,j); window holds rows r-2..r, cols c-2..c.
    function automatic logic [PIX_W-1:0] neighbor_mean(input int i, input int j, input int r,
                                                       input int c, input int w, input int h);
        int          di, dj, y, x, wr, wc;
        int unsigned sr, sg, sb, n;
        logic [PIX_W-1:0] p;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (di = -1; di <= 1; di++) begin
            for (dj = -1; dj <= 1; dj++) begin
                y  = i + di;
                x  = j + dj;
                wr = y - r + 2;
                wc = x - c + 2;
                if (y < 0 || y >= h || x < 0 || x >= w) continue;
                if (wr < 0 || wr > 2 || wc < 0 || wc > 2) continue;
                p  = win[wr * 3 + wc];
                sr += p[23:16];
                sg += p[15:8];
                sb += p[7:0];
                n++;
            end
        end
        if (n == 0) return '0;
        return {rounded_mean(sr, n), rounded_mean(sg, n), rounded_mean(sb, n)};
    endfunction

    function automatic void take_pixel(input logic [PIX_W-1:0] px);
        int               w, h, r, c, i, j, k, cnt;
        logic [PIX_W-1:0] above, above2, v;
        blur_px_t         run [4];
        w = (width_reg == 0) ? 1 : ((int'(width_reg) > LINE_MAX) ? LINE_MAX : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        r = row_pos;
        c = col_pos;
        if (c >= w || r >= h) begin
            r = 0;
            c = 0;
        end
        above2        = older_line[c];
        above         = prev_line[c];
        older_line[c] = above;
        prev_line[c]  = px;
        for (k = 0; k < 3; k++) begin
            win[3 * k]     = win[3 * k + 1];
            win[3 * k + 1] = win[3 * k + 2];
        end
        win[2] = above2;
        win[5] = above;
        win[8] = px;

        // lower-right neighbor releases a pixel; last row / last column flush the rest
        cnt = 0;
        for (i = r - 1; i <= r; i++) begin
            if (i < 0 || (i == r && r != h - 1)) continue;
            for (j = c - 1; j <= c; j++) begin
                if (j < 0 || (j == c && c != w - 1)) continue;
                v = neighbor_mean(i, j, r, c, w, h);
                run[cnt].red   = v[23:16];
                run[cnt].green = v[15:8];
                run[cnt].blue  = v[7:0];
                run[cnt].row   = bb3ea_pkg::ROW_W'(i);
                run[cnt].col   = COL_W'(j);
                run[cnt].last  = 1'b0;
                run[cnt].fend  = (i == h - 1 && j == w - 1);
                cnt++;
            end
        end
        if (cnt > 0) run[cnt - 1].last = 1'b1;
        for (k = 0; k < cnt; k++) blurred_q.push_back(run[k]);

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    task automatic check_result();
        blur_px_t want;
        string    at;
        if (blurred_q.size() == 0) begin
            flag_mismatch($sformatf("result (%0d,%0d) with nothing pending", m_out_row, m_out_col));
            return;
        end
        want = blurred_q.pop_front();
        at   = $sformatf("(%0d,%0d)", want.row, want.col);
        if (m_out_red !== want.red)
            flag_mismatch($sformatf("%s red %0h, want %0h", at, m_out_red, want.red));
        if (m_out_green !== want.green)
            flag_mismatch($sformatf("%s green %0h, want %0h", at, m_out_green, want.green));
        if (m_out_blue !== want.blue)
            flag_mismatch($sformatf("%s blue %0h, want %0h", at, m_out_blue, want.blue));
        if (m_out_row !== want.row)
            flag_mismatch($sformatf("%s row %0d", at, m_out_row));
        if (m_out_col !== want.col)
            flag_mismatch($sformatf("%s col %0d", at, m_out_col));
        if (m_last_of_run !== want.last)
            flag_mismatch($sformatf("%s last_of_run %b, want %b", at, m_last_of_run, want.last));
        if (m_frame_end !== want.fend)
            flag_mismatch($sformatf("%s frame_end %b, want %b", at, m_frame_end, want.fend));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = bb3ea_pkg::IMAGE_WIDTH_RST;
            height_reg = bb3ea_pkg::IMAGE_HEIGHT_RST;
            row_pos    = 0;
            col_pos    = 0;
            fail_count = 0;
            for (int k = 0; k < 9; k++) win[k] = '0;
            for (int k = 0; k < LINE_MAX; k++) begin
                older_line[k] = '0;
                prev_line[k]  = '0;
            end
            blurred_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    bb3ea_pkg::REG_IMAGE_WIDTH: begin
                        width_reg = cfg_wdata[bb3ea_pkg::IMG_W_W-1:0];
                        row_pos   = 0;
                        col_pos   = 0;
                    end
                    bb3ea_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg = cfg_wdata;
                        row_pos    = 0;
                        col_pos    = 0;
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                take_pixel({s_in_red, s_in_green, s_in_blue});
            if (m_valid && m_ready)
                check_result();
        end
        pending <= blurred_q.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus for the 3x3 box blur: directed frames for the size extremes and
// register corner cases, then random frame sizes and pixels under three
// idling mixes and one long result-side hold-off. Checking is in blur_checker.
// ============================================================================
module tb;

    localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
    localparam int FLUSH_CYCLES = 24;    // room for a pixel with the most results to finish, with margin
    localparam int HOLD_CYCLES  = 400;
    localparam int COL_W        = $clog2(bb3ea_pkg::MAX_WIDTH_DEF);

    localparam logic [bb3ea_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [bb3ea_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [bb3ea_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bb3ea_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    logic [bb3ea_pkg::CH_W-1:0]       s_in_red   = '0;
    logic [bb3ea_pkg::CH_W-1:0]       s_in_green = '0;
    logic [bb3ea_pkg::CH_W-1:0]       s_in_blue  = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    logic [bb3ea_pkg::CH_W-1:0]       m_out_red;
    logic [bb3ea_pkg::CH_W-1:0]       m_out_green;
    logic [bb3ea_pkg::CH_W-1:0]       m_out_blue;
    logic [bb3ea_pkg::ROW_W-1:0]      m_out_row;
    logic [COL_W-1:0]                 m_out_col;
    logic                             m_last_of_run;
    logic                             m_frame_end;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int sent_items  = 0;
    int idle_run    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    box_blur_3x3_edge_aware dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_red      (s_in_red),
        .s_in_green    (s_in_green),
        .s_in_blue     (s_in_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_last_of_run (m_last_of_run),
        .m_frame_end   (m_frame_end)
    );

    blur_checker blur_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_red      (s_in_red),
        .s_in_green    (s_in_green),
        .s_in_blue     (s_in_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_last_of_run (m_last_of_run),
        .m_frame_end   (m_frame_end),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever hold_seq moves.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_pixel();
        return {pick_channel(), pick_channel(), pick_channel()};
    endfunction

    task automatic send_pixel(input logic [23:0] px);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_red   <= px[23:16];
        s_in_green <= px[15:8];
        s_in_blue  <= px[7:0];
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    task automatic write_reg(input logic [bb3ea_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bb3ea_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain: every predicted result back, then let pixels with no result finish.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (FLUSH_CYCLES) @(posedge aclk);
    endtask

    task automatic run_frame(input logic [15:0] wval, input logic [15:0] hval, input int npix);
        if ($urandom_range(1)) begin
            write_reg(bb3ea_pkg::REG_IMAGE_WIDTH, wval);
            write_reg(bb3ea_pkg::REG_IMAGE_HEIGHT, hval);
        end else begin
            write_reg(bb3ea_pkg::REG_IMAGE_HEIGHT, hval);
            write_reg(bb3ea_pkg::REG_IMAGE_WIDTH, wval);
        end
        repeat (npix) send_pixel(rand_pixel());
        settle();
    endtask

    // Mostly whole frames; some cut short by a register write, some running into the next.
    task automatic random_frames(input int quota);
        int          start, w, h, full, npix;
        logic [15:0] wval;
        start = sent_items;
        while (sent_items - start < quota) begin
            case ($urandom_range(9))
                0: w = 0;
                1: w = $urandom_range(20, 7);
                default: w = $urandom_range(6, 1);
            endcase
            case ($urandom_range(9))
                0: h = 0;
                1: h = $urandom_range(8, 6);
                default: h = $urandom_range(5, 1);
            endcase
            full = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            case ($urandom_range(9))
                0: npix = $urandom_range(full - 1);
                1: npix = full + $urandom_range(full, 1);
                default: npix = full;
            endcase
            wval = 16'(w);
            if ($urandom_range(3) == 0) wval[15:11] = 5'($urandom);
            run_frame(wval, 16'(h), npix);
        end
    endtask

    initial begin
        tx_idle_pct = 33;
        rx_idle_pct = 84;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size: a partial first row, dropped by the next write
        send_pixel(24'h123456);
        send_pixel(24'hFEDCBA);
        settle();

        // zero sizes act as a 1x1 frame; second pixel wraps to a new frame
        write_reg(bb3ea_pkg::REG_IMAGE_WIDTH, 16'd0);
        write_reg(bb3ea_pkg::REG_IMAGE_HEIGHT, 16'd0);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        settle();

        // 3x3: corners, edges and center; writes to unused indexes mid-frame
        write_reg(bb3ea_pkg::REG_IMAGE_WIDTH, 16'd3);
        write_reg(bb3ea_pkg::REG_IMAGE_HEIGHT, 16'd3);
        send_pixel(24'hFF00FF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000001);
        settle();
        write_reg(REG_SPARE2, 16'hFFFF);
        write_reg(REG_SPARE3, 16'h0000);
        send_pixel(24'hFF0000);
        send_pixel(24'h01FE7F);
        send_pixel(24'h000000);
        send_pixel(24'h80FF01);
        send_pixel(24'hFFFFFF);
        settle();

        // width 2 through masked upper bits, one row: half-way rounding up
        run_frame(16'hF802, 16'd1, 0);
        send_pixel(24'h0100FF);
        send_pixel(24'h020100);
        settle();

        // one pixel wide, three high
        run_frame(16'd1, 16'd3, 3);

        random_frames(40);

        tx_idle_pct = 84;
        rx_idle_pct = 33;
        random_frames(40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_seq++;
        random_frames(40);

        // oversize width, start of a single row; then the tallest frame, briefly
        run_frame(16'hFFFF, 16'd1, 24);
        run_frame(16'd1, 16'hFFFF, 6);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
